// File: hw/rtl/indent_aware_char_lexer_defines.svh
// ----------------------------------------------------------------------------
// indent_aware_char_lexer_defines.svh
// assertion macros shared by the lexer rtl
// ----------------------------------------------------------------------------
`ifndef INDENT_AWARE_CHAR_LEXER_DEFINES_SVH
`define INDENT_AWARE_CHAR_LEXER_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define IACL_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("iacl: same-cycle check failed");

// next-cycle implication, clocked on clock, off during reset
`define IACL_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("iacl: next-cycle check failed");

`endif

// File: hw/rtl/iacl_pkg.sv
// ----------------------------------------------------------------------------
// iacl_pkg
// shared types and constants of the indentation-aware character lexer
// ----------------------------------------------------------------------------
package iacl_pkg;

   // item function codes
   localparam logic [1:0] FUNC_CHAR = 2'd0;
   localparam logic [1:0] FUNC_END  = 2'd1;
   localparam logic [1:0] FUNC_PUSH = 2'd2;

   // token kinds
   localparam logic [2:0] KIND_END     = 3'd0;
   localparam logic [2:0] KIND_DOWN    = 3'd1;
   localparam logic [2:0] KIND_UP      = 3'd2;
   localparam logic [2:0] KIND_SPACE   = 3'd3;
   localparam logic [2:0] KIND_NEWLINE = 3'd4;
   localparam logic [2:0] KIND_PUNCT   = 3'd5;
   localparam logic [2:0] KIND_NORMAL  = 3'd6;

   // character codes
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;

   // sequencer states
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_READ  = 7'b0000010,
      ST_CHECK = 7'b0000100,
      ST_SPACE = 7'b0001000,
      ST_CHAR  = 7'b0010000,
      ST_DRAIN = 7'b0100000,
      ST_END   = 7'b1000000
   } state_type;

   // stack memory port controls
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } stk_cmd_type;

endpackage

// File: hw/rtl/iacl_stack_ram.sv
// ----------------------------------------------------------------------------
// iacl_stack_ram
// indent column stack storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module iacl_stack_ram #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 12
) (
   input  logic                      clock,
   input  iacl_pkg::stk_cmd_type     cmd,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [DATA_W-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [DATA_W-1:0]         rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/indent_aware_char_lexer.sv
// ----------------------------------------------------------------------------
// indent_aware_char_lexer
// character lexer that tracks line, column, space runs and a stack of
// indent columns, emitting one token per output transaction
// ----------------------------------------------------------------------------
// channel  direction  fields
// req_     in         func, char_code, indent_value
// rsp_     out        token_kind, token_char, space_length, begin/end line
//                     and column, last
//
// an item that yields no token (push, leading space, blank line, space in
// content) is taken while idle; otherwise the next item waits until its tokens are out.
// a character at a line start with a non-empty stack reads and compares
// stack entries (memory read, then compare): one per pop, plus one more
// unless the stack empties. reset is synchronous; the stack memory is not
// cleared, the fill count is. a stalled rsp_ side holds the sequencer.
// ----------------------------------------------------------------------------
`include "indent_aware_char_lexer_defines.svh"

module indent_aware_char_lexer #(
   parameter int STACK_DEPTH = 16,
   parameter int COLUMN_BITS = 12,
   parameter int LINE_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic [7:0]             req_char_code,
   input  logic [COLUMN_BITS-1:0] req_indent_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_token_kind,
   output logic [7:0]             rsp_token_char,
   output logic [COLUMN_BITS-1:0] rsp_space_length,
   output logic [LINE_BITS-1:0]   rsp_begin_line,
   output logic [COLUMN_BITS-1:0] rsp_begin_column,
   output logic [LINE_BITS-1:0]   rsp_end_line,
   output logic [COLUMN_BITS-1:0] rsp_end_column,
   output logic                   rsp_last
);

   localparam int FILL_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W  = $clog2(STACK_DEPTH);
   localparam logic [FILL_W-1:0]      FILL_FULL = FILL_W'(STACK_DEPTH);
   localparam logic [FILL_W-1:0]      FILL_ONE  = FILL_W'(1);
   localparam logic [COLUMN_BITS-1:0] COL_MAX   = {COLUMN_BITS{1'b1}};
   localparam logic [COLUMN_BITS-1:0] COL_ONE   = COLUMN_BITS'(1);
   localparam logic [LINE_BITS-1:0]   LINE_MAX  = {LINE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   LINE_ONE  = LINE_BITS'(1);

   iacl_pkg::state_type     state_ff, state_in;
   logic                    mode_ff, mode_in;
   logic [LINE_BITS-1:0]    line_ff, line_in;
   logic [COLUMN_BITS-1:0]  col_ff, col_in;
   logic [COLUMN_BITS-1:0]  run_len_ff, run_len_in;
   logic [COLUMN_BITS-1:0]  run_start_ff, run_start_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [7:0]              ch_ff, ch_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              kind_ff, kind_in;
   logic [7:0]              tchar_ff, tchar_in;
   logic [COLUMN_BITS-1:0]  slen_ff, slen_in;
   logic [LINE_BITS-1:0]    bline_ff, bline_in;
   logic [COLUMN_BITS-1:0]  bcol_ff, bcol_in;
   logic [LINE_BITS-1:0]    eline_ff, eline_in;
   logic [COLUMN_BITS-1:0]  ecol_ff, ecol_in;
   logic                    last_ff, last_in;

   logic                    emit;
   logic                    slot_free;
   logic                    accept;
   logic [COLUMN_BITS-1:0]  col_next;
   logic [LINE_BITS-1:0]    line_next;
   logic [FILL_W-1:0]       fill_m1;
   logic [COLUMN_BITS-1:0]  top_col;
   logic                    is_punct;
   iacl_pkg::stk_cmd_type   stk_cmd;

   // stack storage
   iacl_stack_ram #(
      .DEPTH  (STACK_DEPTH),
      .DATA_W (COLUMN_BITS)
   ) u_stack (
      .clock   (clock),
      .cmd     (stk_cmd),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (req_indent_value),
      .rd_addr (fill_m1[IDX_W-1:0]),
      .rd_data (top_col)
   );

   // handshake and helpers
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == iacl_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign col_next  = (col_ff == COL_MAX) ? col_ff : col_ff + COL_ONE;
   assign line_next = (line_ff == LINE_MAX) ? line_ff : line_ff + LINE_ONE;
   assign fill_m1   = fill_ff - FILL_ONE;
   assign is_punct  = ch_ff inside {iacl_pkg::CH_DASH, iacl_pkg::CH_COLON,
                                    iacl_pkg::CH_COMMA, iacl_pkg::CH_LBRACK,
                                    iacl_pkg::CH_RBRACK, iacl_pkg::CH_LBRACE,
                                    iacl_pkg::CH_RBRACE, iacl_pkg::CH_LPAREN,
                                    iacl_pkg::CH_RPAREN};

   assign stk_cmd.wr_en = accept && (req_func == iacl_pkg::FUNC_PUSH) && (fill_ff < FILL_FULL);
   assign stk_cmd.rd_en = (state_ff == iacl_pkg::ST_READ);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      line_in      = line_ff;
      col_in       = col_ff;
      run_len_in   = run_len_ff;
      run_start_in = run_start_ff;
      fill_in      = fill_ff;
      ch_in        = ch_ff;
      emit         = 1'b0;
      kind_in      = iacl_pkg::KIND_END;
      tchar_in     = 8'd0;
      slen_in      = '0;
      bline_in     = line_ff;
      bcol_in      = col_ff;
      eline_in     = line_ff;
      ecol_in      = col_ff;
      last_in      = 1'b0;

      case (state_ff)
         iacl_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  iacl_pkg::FUNC_PUSH: begin
                     if (fill_ff < FILL_FULL) begin
                        fill_in = fill_ff + FILL_ONE;
                     end
                  end
                  iacl_pkg::FUNC_END: begin
                     state_in = (fill_ff != '0) ? iacl_pkg::ST_DRAIN : iacl_pkg::ST_END;
                  end
                  iacl_pkg::FUNC_CHAR: begin
                     ch_in = req_char_code;
                     if (!mode_ff) begin
                        // line start: blank lines and leading spaces
                        if (req_char_code == iacl_pkg::CH_NL) begin
                           line_in = line_next;
                           col_in  = COL_ONE;
                        end else if (req_char_code == iacl_pkg::CH_SPACE) begin
                           col_in = col_next;
                        end else begin
                           state_in = (fill_ff != '0) ? iacl_pkg::ST_READ
                                                      : iacl_pkg::ST_CHAR;
                        end
                     end else begin
                        // in content: spaces build a run
                        if (req_char_code == iacl_pkg::CH_SPACE) begin
                           if (run_len_ff == '0) begin
                              run_start_in = col_ff;
                           end
                           if (run_len_ff != COL_MAX) begin
                              run_len_in = run_len_ff + COL_ONE;
                           end
                           col_in = col_next;
                        end else begin
                           state_in = (run_len_ff != '0) ? iacl_pkg::ST_SPACE
                                                         : iacl_pkg::ST_CHAR;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         iacl_pkg::ST_READ: begin
            state_in = iacl_pkg::ST_CHECK;
         end
         iacl_pkg::ST_CHECK: begin
            // compare the column against the top of the stack
            if (col_ff < top_col) begin
               if (slot_free) begin
                  emit     = 1'b1;
                  kind_in  = iacl_pkg::KIND_DOWN;
                  fill_in  = fill_m1;
                  state_in = (fill_m1 != '0) ? iacl_pkg::ST_READ : iacl_pkg::ST_CHAR;
               end
            end else if (col_ff > top_col) begin
               if (slot_free) begin
                  emit     = 1'b1;
                  kind_in  = iacl_pkg::KIND_UP;
                  state_in = iacl_pkg::ST_CHAR;
               end
            end else begin
               state_in = iacl_pkg::ST_CHAR;
            end
         end
         iacl_pkg::ST_SPACE: begin
            if (slot_free) begin
               emit       = 1'b1;
               kind_in    = iacl_pkg::KIND_SPACE;
               slen_in    = run_len_ff;
               bcol_in    = run_start_ff;
               run_len_in = '0;
               state_in   = iacl_pkg::ST_CHAR;
            end
         end
         iacl_pkg::ST_CHAR: begin
            if (slot_free) begin
               emit     = 1'b1;
               last_in  = 1'b1;
               state_in = iacl_pkg::ST_IDLE;
               if (ch_ff == iacl_pkg::CH_NL) begin
                  kind_in = iacl_pkg::KIND_NEWLINE;
                  line_in = line_next;
                  col_in  = COL_ONE;
                  mode_in = 1'b0;
               end else begin
                  kind_in  = is_punct ? iacl_pkg::KIND_PUNCT : iacl_pkg::KIND_NORMAL;
                  tchar_in = ch_ff;
                  ecol_in  = col_next;
                  col_in   = col_next;
                  mode_in  = 1'b1;
               end
            end
         end
         iacl_pkg::ST_DRAIN: begin
            if (slot_free) begin
               emit    = 1'b1;
               kind_in = iacl_pkg::KIND_DOWN;
               fill_in = fill_m1;
               if (fill_m1 == '0) begin
                  state_in = iacl_pkg::ST_END;
               end
            end
         end
         iacl_pkg::ST_END: begin
            if (slot_free) begin
               emit         = 1'b1;
               kind_in      = iacl_pkg::KIND_END;
               last_in      = 1'b1;
               state_in     = iacl_pkg::ST_IDLE;
               mode_in      = 1'b0;
               line_in      = LINE_ONE;
               col_in       = COL_ONE;
               run_len_in   = '0;
               run_start_in = COL_ONE;
               fill_in      = '0;
            end
         end
         default: begin
            state_in = iacl_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iacl_pkg::ST_IDLE;
         mode_ff      <= 1'b0;
         line_ff      <= LINE_ONE;
         col_ff       <= COL_ONE;
         run_len_ff   <= '0;
         run_start_ff <= COL_ONE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         run_len_ff   <= run_len_in;
         run_start_ff <= run_start_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // latched character and output token
   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
      if (emit) begin
         kind_ff  <= kind_in;
         tchar_ff <= tchar_in;
         slen_ff  <= slen_in;
         bline_ff <= bline_in;
         bcol_ff  <= bcol_in;
         eline_ff <= eline_in;
         ecol_ff  <= ecol_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_kind   = kind_ff;
   assign rsp_token_char   = tchar_ff;
   assign rsp_space_length = slen_ff;
   assign rsp_begin_line   = bline_ff;
   assign rsp_begin_column = bcol_ff;
   assign rsp_end_line     = eline_ff;
   assign rsp_end_column   = ecol_ff;
   assign rsp_last         = last_ff;

   // checks
   `IACL_ASSERT_IMP(a_fill_bound, 1'b1, fill_ff <= FILL_FULL)
   `IACL_ASSERT_NXT(a_read_then_check, state_ff == iacl_pkg::ST_READ, state_ff == iacl_pkg::ST_CHECK)
   `IACL_ASSERT_NXT(a_end_clears, (state_ff == iacl_pkg::ST_END) && slot_free, (fill_ff == '0) && !mode_ff)
   `IACL_ASSERT_NXT(a_push_grows, stk_cmd.wr_en, fill_ff == $past(fill_ff) + FILL_ONE)

endmodule

// File: tb/sv/indent_aware_char_lexer_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indent_aware_char_lexer_check
// watches both channels of the lexer, predicts the token stream from each
// accepted input transaction and compares every output transaction against
// the oldest awaited token, field by field
// ----------------------------------------------------------------------------
module indent_aware_char_lexer_check #(
   parameter int STACK_DEPTH = 16,
   parameter int COLUMN_BITS = 12,
   parameter int LINE_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic [7:0]             req_char_code,
   input  logic [COLUMN_BITS-1:0] req_indent_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [2:0]             rsp_token_kind,
   input  logic [7:0]             rsp_token_char,
   input  logic [COLUMN_BITS-1:0] rsp_space_length,
   input  logic [LINE_BITS-1:0]   rsp_begin_line,
   input  logic [COLUMN_BITS-1:0] rsp_begin_column,
   input  logic [LINE_BITS-1:0]   rsp_end_line,
   input  logic [COLUMN_BITS-1:0] rsp_end_column,
   input  logic                   rsp_last,
   output int                     mismatch_count,
   output int                     pending_tokens,
   output int                     items_taken,
   output int                     tokens_seen
);

   localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam int                     IDX_W    = $clog2(STACK_DEPTH);

   typedef struct packed {
      logic [2:0]             kind;
      logic [7:0]             ch;
      logic [COLUMN_BITS-1:0] slen;
      logic [LINE_BITS-1:0]   bline;
      logic [COLUMN_BITS-1:0] bcol;
      logic [LINE_BITS-1:0]   eline;
      logic [COLUMN_BITS-1:0] ecol;
      logic                   last;
   } lexed_token_type;

   // predicted lexer state
   logic                   content_mode;
   logic [LINE_BITS-1:0]   line_no;
   logic [COLUMN_BITS-1:0] col_no;
   logic [COLUMN_BITS-1:0] run_len;
   logic [COLUMN_BITS-1:0] run_start;
   logic [COLUMN_BITS-1:0] indent_cols [STACK_DEPTH];
   int                     indent_depth;

   lexed_token_type awaited_tokens [$];
   lexed_token_type want_tok;
   int              batch_size;
   int              miss_total;
   int              item_total;
   int              token_total;

   // one line per mismatch
   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      miss_total++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("token %0d %s got %0d expected %0d",
                                   token_total, name, got, want));
   endtask

   function automatic logic [COLUMN_BITS-1:0] col_step(input logic [COLUMN_BITS-1:0] c);
      return (c == COL_MAX) ? COL_MAX : c + 1'b1;
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return c == iacl_pkg::CH_DASH || c == iacl_pkg::CH_COLON ||
             c == iacl_pkg::CH_COMMA || c == iacl_pkg::CH_LBRACK ||
             c == iacl_pkg::CH_RBRACK || c == iacl_pkg::CH_LBRACE ||
             c == iacl_pkg::CH_RBRACE || c == iacl_pkg::CH_LPAREN ||
             c == iacl_pkg::CH_RPAREN;
   endfunction

   task automatic clear_lexer();
      content_mode = 1'b0;
      line_no      = LINE_BITS'(1);
      col_no       = COLUMN_BITS'(1);
      run_len      = '0;
      run_start    = COLUMN_BITS'(1);
      indent_depth = 0;
   endtask

   task automatic next_line();
      if (line_no != LINE_MAX)
         line_no++;
      col_no = COLUMN_BITS'(1);
   endtask

   task automatic put_token(input logic [2:0] kind, input logic [7:0] ch,
                            input logic [COLUMN_BITS-1:0] slen,
                            input logic [COLUMN_BITS-1:0] bcol,
                            input logic [COLUMN_BITS-1:0] ecol);
      lexed_token_type tok;
      tok.kind  = kind;
      tok.ch    = ch;
      tok.slen  = slen;
      tok.bline = line_no;
      tok.bcol  = bcol;
      tok.eline = line_no;
      tok.ecol  = ecol;
      tok.last  = 1'b0;
      awaited_tokens.push_back(tok);
      batch_size++;
   endtask

   // tokens that sit at the current position: indents, newline, end
   task automatic put_here(input logic [2:0] kind);
      put_token(kind, 8'h00, '0, col_no, col_no);
   endtask

   task automatic put_char(input logic [7:0] c);
      logic [COLUMN_BITS-1:0] bcol;
      bcol   = col_no;
      col_no = col_step(col_no);
      put_token(is_punct(c) ? iacl_pkg::KIND_PUNCT : iacl_pkg::KIND_NORMAL, c, '0,
                bcol, col_no);
   endtask

   // advance the predicted lexer by one input transaction
   task automatic lex_item(input logic [1:0] func, input logic [7:0] c,
                           input logic [COLUMN_BITS-1:0] column);
      lexed_token_type tok;
      batch_size = 0;
      case (func)
         iacl_pkg::FUNC_PUSH: begin
            if (indent_depth < STACK_DEPTH) begin
               indent_cols[IDX_W'(indent_depth)] = column;
               indent_depth++;
            end
         end
         iacl_pkg::FUNC_END: begin
            // pending spaces dropped, every indent closed, then end
            while (indent_depth > 0) begin
               indent_depth--;
               put_here(iacl_pkg::KIND_DOWN);
            end
            put_here(iacl_pkg::KIND_END);
            clear_lexer();
         end
         iacl_pkg::FUNC_CHAR: begin
            if (!content_mode) begin
               if (c == iacl_pkg::CH_NL) begin
                  next_line();
               end else if (c == iacl_pkg::CH_SPACE) begin
                  col_no = col_step(col_no);
               end else begin
                  // first visible character of a line settles the indent
                  while (indent_depth > 0 &&
                         col_no < indent_cols[IDX_W'(indent_depth - 1)]) begin
                     indent_depth--;
                     put_here(iacl_pkg::KIND_DOWN);
                  end
                  if (indent_depth > 0 && col_no > indent_cols[IDX_W'(indent_depth - 1)])
                     put_here(iacl_pkg::KIND_UP);
                  content_mode = 1'b1;
                  put_char(c);
               end
            end else if (c == iacl_pkg::CH_SPACE) begin
               if (run_len == 0)
                  run_start = col_no;
               if (run_len != COL_MAX)
                  run_len++;
               col_no = col_step(col_no);
            end else begin
               if (run_len != 0) begin
                  put_token(iacl_pkg::KIND_SPACE, 8'h00, run_len, run_start, col_no);
                  run_len = '0;
               end
               if (c == iacl_pkg::CH_NL) begin
                  put_here(iacl_pkg::KIND_NEWLINE);
                  next_line();
                  content_mode = 1'b0;
               end else begin
                  put_char(c);
               end
            end
         end
         default: ;
      endcase
      // flag the final token of this transaction
      if (batch_size > 0) begin
         tok = awaited_tokens.pop_back();
         tok.last = 1'b1;
         awaited_tokens.push_back(tok);
      end
   endtask

   // sample both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         clear_lexer();
         awaited_tokens.delete();
         miss_total  = 0;
         item_total  = 0;
         token_total = 0;
      end else begin
         if (req_valid && req_ready) begin
            item_total++;
            lex_item(req_func, req_char_code, req_indent_value);
         end
         if (rsp_valid && rsp_ready) begin
            token_total++;
            if (awaited_tokens.size() == 0) begin
               report_mismatch($sformatf("token %0d kind %0d arrived with none awaited",
                                         token_total, rsp_token_kind));
            end else begin
               want_tok = awaited_tokens.pop_front();
               check_field("kind", 32'(rsp_token_kind), 32'(want_tok.kind));
               check_field("char", 32'(rsp_token_char), 32'(want_tok.ch));
               check_field("space_length", 32'(rsp_space_length), 32'(want_tok.slen));
               check_field("begin_line", 32'(rsp_begin_line), 32'(want_tok.bline));
               check_field("begin_column", 32'(rsp_begin_column), 32'(want_tok.bcol));
               check_field("end_line", 32'(rsp_end_line), 32'(want_tok.eline));
               check_field("end_column", 32'(rsp_end_column), 32'(want_tok.ecol));
               check_field("last", 32'(rsp_last), 32'(want_tok.last));
            end
         end
      end
      mismatch_count <= miss_total;
      pending_tokens <= awaited_tokens.size();
      items_taken    <= item_total;
      tokens_seen    <= token_total;
   end

endmodule

// File: tb/sv/indent_aware_char_lexer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indent_aware_char_lexer_tb
// drives the lexer with directed corner cases, random indented documents and
// a full-stack unwind, with random idling on both channels; the token
// checker beside the block predicts and compares, this module gives verdict
// ----------------------------------------------------------------------------
module indent_aware_char_lexer_tb;

   localparam int         STACK_DEPTH  = 16;
   localparam int         COLUMN_BITS  = 12;
   localparam int         LINE_BITS    = 16;
   localparam int         RANDOM_ITEMS = 60;
   localparam int         LONG_HOLD    = 200;
   localparam int         TAIL_CYCLES  = 64;
   localparam int         LIMIT_CYCLES = 800000;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_func = iacl_pkg::FUNC_CHAR;
   logic [7:0]             req_char_code = 8'h00;
   logic [COLUMN_BITS-1:0] req_indent_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [2:0]             rsp_token_kind;
   logic [7:0]             rsp_token_char;
   logic [COLUMN_BITS-1:0] rsp_space_length;
   logic [LINE_BITS-1:0]   rsp_begin_line;
   logic [COLUMN_BITS-1:0] rsp_begin_column;
   logic [LINE_BITS-1:0]   rsp_end_line;
   logic [COLUMN_BITS-1:0] rsp_end_column;
   logic                   rsp_last;

   int mismatch_count;
   int pending_tokens;
   int items_taken;
   int tokens_seen;

   // stimulus-side controls
   bit quiet   = 1'b0;
   bit squeeze = 1'b0;
   int counted_items = 0;

   indent_aware_char_lexer #(
      .STACK_DEPTH (STACK_DEPTH),
      .COLUMN_BITS (COLUMN_BITS),
      .LINE_BITS   (LINE_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_char_code    (req_char_code),
      .req_indent_value (req_indent_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_char   (rsp_token_char),
      .rsp_space_length (rsp_space_length),
      .rsp_begin_line   (rsp_begin_line),
      .rsp_begin_column (rsp_begin_column),
      .rsp_end_line     (rsp_end_line),
      .rsp_end_column   (rsp_end_column),
      .rsp_last         (rsp_last)
   );

   indent_aware_char_lexer_check #(
      .STACK_DEPTH (STACK_DEPTH),
      .COLUMN_BITS (COLUMN_BITS),
      .LINE_BITS   (LINE_BITS)
   ) token_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_char_code    (req_char_code),
      .req_indent_value (req_indent_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_char   (rsp_token_char),
      .rsp_space_length (rsp_space_length),
      .rsp_begin_line   (rsp_begin_line),
      .rsp_begin_column (rsp_begin_column),
      .rsp_end_line     (rsp_end_line),
      .rsp_end_column   (rsp_end_column),
      .rsp_last         (rsp_last),
      .mismatch_count   (mismatch_count),
      .pending_tokens   (pending_tokens),
      .items_taken      (items_taken),
      .tokens_seen      (tokens_seen)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(LIMIT_CYCLES * 12);
      $display("timeout after %0d cycles", LIMIT_CYCLES);
      $display("end of test: mismatches");
      $finish;
   end

   // one input transaction, with a random gap unless in a quiet stretch
   task automatic send_item(input logic [1:0] func, input logic [7:0] code,
                            input logic [COLUMN_BITS-1:0] column);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_char_code    <= code;
      req_indent_value <= column;
      do @(posedge clock); while (!(req_valid && req_ready));
      if (func != FUNC_UNUSED)
         counted_items++;
   endtask

   task automatic feed_char(input logic [7:0] code);
      send_item(iacl_pkg::FUNC_CHAR, code, COLUMN_BITS'($urandom_range(0, 4095)));
   endtask

   task automatic send_run(input logic [7:0] code, input int count);
      int i;
      for (i = 0; i < count; i++)
         feed_char(code);
   endtask

   task automatic send_push(input logic [COLUMN_BITS-1:0] column);
      send_item(iacl_pkg::FUNC_PUSH, 8'($urandom_range(0, 255)), column);
   endtask

   task automatic end_input();
      send_item(iacl_pkg::FUNC_END, 8'($urandom_range(0, 255)),
                COLUMN_BITS'($urandom_range(0, 4095)));
   endtask

   function automatic logic [7:0] pick_char();
      int roll;
      roll = $urandom_range(0, 11);
      if (roll < 3) begin
         case ($urandom_range(0, 8))
            0: return iacl_pkg::CH_DASH;
            1: return iacl_pkg::CH_COLON;
            2: return iacl_pkg::CH_COMMA;
            3: return iacl_pkg::CH_LBRACK;
            4: return iacl_pkg::CH_RBRACK;
            5: return iacl_pkg::CH_LBRACE;
            6: return iacl_pkg::CH_RBRACE;
            7: return iacl_pkg::CH_LPAREN;
            default: return iacl_pkg::CH_RPAREN;
         endcase
      end
      if (roll < 5)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   // a short indented document: pushes, lines of words, blank lines, noise
   task automatic random_document();
      int lines, ln, words, wd, letters, k;
      lines = $urandom_range(2, 8);
      for (ln = 0; ln < lines; ln++) begin
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0)
            send_push(($urandom_range(0, 7) == 0)
                      ? COLUMN_BITS'($urandom_range(0, 4095))
                      : COLUMN_BITS'(2 * $urandom_range(0, 3) + 1));
         if ($urandom_range(0, 19) == 0)
            send_item(FUNC_UNUSED, 8'($urandom_range(0, 255)),
                      COLUMN_BITS'($urandom_range(0, 4095)));
         send_run(iacl_pkg::CH_SPACE, 2 * $urandom_range(0, 3));
         if ($urandom_range(0, 7) != 0) begin
            words = $urandom_range(1, 3);
            for (wd = 0; wd < words; wd++) begin
               if (wd > 0)
                  send_run(iacl_pkg::CH_SPACE, $urandom_range(1, 3));
               letters = $urandom_range(1, 4);
               for (k = 0; k < letters; k++)
                  feed_char(pick_char());
            end
            if ($urandom_range(0, 3) == 0)
               send_run(iacl_pkg::CH_SPACE, $urandom_range(1, 2));
         end
         if (ln < lines - 1 || $urandom_range(0, 1) == 0)
            feed_char(iacl_pkg::CH_NL);
      end
      end_input();
   endtask

   // output side: random stalls, quick stretches, one long hold-off
   initial begin : drain_tokens
      int gap;
      bit rush;
      bit squeezed;
      rush     = 1'b0;
      squeezed = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            rush = !rush;
         if (squeeze && !squeezed) begin
            gap      = LONG_HOLD;
            squeezed = 1'b1;
         end else begin
            gap = rush ? 0 : $urandom_range(0, 11);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      int i;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed corners: field extremes, each function, special cases
      feed_char("a");
      send_run(iacl_pkg::CH_SPACE, 2);
      feed_char(iacl_pkg::CH_COLON);
      feed_char(8'hFF);
      feed_char(8'h00);
      feed_char(iacl_pkg::CH_NL);
      feed_char(iacl_pkg::CH_NL);
      send_push(12'd3);
      send_push(12'hFFF);
      feed_char(iacl_pkg::CH_SPACE);
      feed_char("x");
      feed_char(iacl_pkg::CH_SPACE);
      send_item(FUNC_UNUSED, 8'hFF, 12'hFFF);
      feed_char(iacl_pkg::CH_NL);
      send_push(12'd0);
      feed_char(iacl_pkg::CH_DASH);
      feed_char(iacl_pkg::CH_SPACE);
      end_input();
      send_push(12'd5);
      send_run(iacl_pkg::CH_SPACE, 4);
      feed_char("k");
      end_input();

      // random indented documents, with one long output hold early on
      squeeze       = 1'b1;
      counted_items = 0;
      while (counted_items < RANDOM_ITEMS)
         random_document();

      // long bursts with no input gaps
      quiet = 1'b1;

      // full stack: one extra push dropped, then a deep unwind with indent up
      send_push(12'd1);
      for (i = 0; i < STACK_DEPTH - 1; i++)
         send_push(12'hFFF);
      send_push(12'd7);
      feed_char(iacl_pkg::CH_SPACE);
      feed_char("f");
      feed_char(iacl_pkg::CH_NL);
      end_input();
      for (i = 0; i < STACK_DEPTH; i++)
         send_push(COLUMN_BITS'(i + 1));
      end_input();

      // trailing space dropped at end of input
      feed_char("x");
      feed_char(iacl_pkg::CH_NL);
      feed_char("y");
      feed_char(iacl_pkg::CH_SPACE);
      end_input();

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_tokens != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("summary: %0d input transactions taken, %0d tokens compared",
               items_taken, tokens_seen);
      $display("summary: corner items, random indented text, full stack, long output hold");
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/iacl_pkg.sv
hw/rtl/iacl_stack_ram.sv
hw/rtl/indent_aware_char_lexer.sv
tb/sv/indent_aware_char_lexer_check.sv
tb/sv/indent_aware_char_lexer_tb.sv
